/* design/wave_texture_blit_address_gen_macros.svh */
// Assertion helpers used by the address generator back part.
`ifndef WAVE_TEXTURE_BLIT_ADDRESS_GEN_MACROS_SVH
`define WAVE_TEXTURE_BLIT_ADDRESS_GEN_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define WTB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked on the edge after the antecedent.
`define WTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/wtb_pkg.sv */
package wtb_pkg;

  localparam int MAX_SCREEN_DIM  = 2048;
  localparam int MAX_TEXTURE_DIM = 1024;
  localparam int WAVE_TABLE_SIZE = 256;

  localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_TEXTURE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TEXTURE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_WAVE_AMPLITUDE = 3'd4;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_CLIPPED  = 2'd1;
  localparam logic [1:0] ST_PIXEL    = 2'd2;
  localparam logic [1:0] ST_IDLE     = 2'd3;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic        advance;
    logic        reject;
    logic [10:0] clip_left;
    logic [11:0] clip_width;
    logic [10:0] dest_row;
    logic [11:0] rows;
    logic [15:0] offset_x;
    logic [15:0] offset_y;
    logic [7:0]  phase;
    logic [7:0]  step;
  } wtb_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] src_address;
    logic [21:0] dst_address;
    logic        row_end;
    logic        last;
  } wtb_res_t;

  // Quarter-wave sine, Q1.14.
  function automatic logic [14:0] qsin(input logic [6:0] k);
    logic [14:0] r;
    case (k)
      7'd0: r = 15'd0;      7'd1: r = 15'd402;    7'd2: r = 15'd804;
      7'd3: r = 15'd1205;   7'd4: r = 15'd1606;   7'd5: r = 15'd2006;
      7'd6: r = 15'd2404;   7'd7: r = 15'd2801;   7'd8: r = 15'd3196;
      7'd9: r = 15'd3590;   7'd10: r = 15'd3981;  7'd11: r = 15'd4370;
      7'd12: r = 15'd4756;  7'd13: r = 15'd5139;  7'd14: r = 15'd5520;
      7'd15: r = 15'd5897;  7'd16: r = 15'd6270;  7'd17: r = 15'd6639;
      7'd18: r = 15'd7005;  7'd19: r = 15'd7366;  7'd20: r = 15'd7723;
      7'd21: r = 15'd8076;  7'd22: r = 15'd8423;  7'd23: r = 15'd8765;
      7'd24: r = 15'd9102;  7'd25: r = 15'd9434;  7'd26: r = 15'd9760;
      7'd27: r = 15'd10080; 7'd28: r = 15'd10394; 7'd29: r = 15'd10702;
      7'd30: r = 15'd11003; 7'd31: r = 15'd11297; 7'd32: r = 15'd11585;
      7'd33: r = 15'd11866; 7'd34: r = 15'd12140; 7'd35: r = 15'd12406;
      7'd36: r = 15'd12665; 7'd37: r = 15'd12916; 7'd38: r = 15'd13160;
      7'd39: r = 15'd13395; 7'd40: r = 15'd13623; 7'd41: r = 15'd13842;
      7'd42: r = 15'd14053; 7'd43: r = 15'd14256; 7'd44: r = 15'd14449;
      7'd45: r = 15'd14635; 7'd46: r = 15'd14811; 7'd47: r = 15'd14978;
      7'd48: r = 15'd15137; 7'd49: r = 15'd15286; 7'd50: r = 15'd15426;
      7'd51: r = 15'd15557; 7'd52: r = 15'd15679; 7'd53: r = 15'd15791;
      7'd54: r = 15'd15893; 7'd55: r = 15'd15986; 7'd56: r = 15'd16069;
      7'd57: r = 15'd16143; 7'd58: r = 15'd16207; 7'd59: r = 15'd16261;
      7'd60: r = 15'd16305; 7'd61: r = 15'd16340; 7'd62: r = 15'd16364;
      7'd63: r = 15'd16379; 7'd64: r = 15'd16384;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

  // (sine + 1) in Q.14 for an 8-bit phase, built from the quarter wave.
  function automatic logic [15:0] sine_plus_one(input logic [7:0] p);
    logic [15:0] s;
    logic [7:0]  k;
    k = 8'd0;
    case (p[7:6])
      2'd0: k = p;
      2'd1: k = 8'd128 - p;
      2'd2: k = p - 8'd128;
      default: k = 8'd0 - p;
    endcase
    if (!p[7]) begin
      s = 16'd16384 + {1'b0, qsin(k[6:0])};
    end else begin
      s = 16'd16384 - {1'b0, qsin(k[6:0])};
    end
    return s;
  endfunction

endpackage

/* design/wtb_if.sv */
interface wtb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  logic [12:0] rect_width;
  logic [12:0] rect_height;
  logic [15:0] tex_offset_x;
  logic [15:0] tex_offset_y;
  logic [7:0]  wave_phase;
  logic [7:0]  wave_step;
  modport source (output valid, mode, dest_x, dest_y, rect_width, rect_height,
                  tex_offset_x, tex_offset_y, wave_phase, wave_step, input ready);
  modport sink (input valid, mode, dest_x, dest_y, rect_width, rect_height,
                tex_offset_x, tex_offset_y, wave_phase, wave_step, output ready);
endinterface

/* design/wtb_out_if.sv */
interface wtb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] src_address;
  logic [21:0] dst_address;
  logic        row_end;
  logic        last;
  modport source (output valid, status, src_address, dst_address, row_end, last,
                  input ready);
  modport sink (input valid, status, src_address, dst_address, row_end, last,
                output ready);
endinterface

/* design/wtb_cfg_if.sv */
interface wtb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/wtb_front.sv */
module wtb_front
  import wtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  wtb_in_if.sink      in_ch,
  input  logic [11:0] sw,
  input  logic [11:0] sh,
  output logic        q_valid,
  input  logic        q_ready,
  output wtb_cmd_t    q_cmd
);

  logic signed [13:0] x0, y0, w0, h0, xc, yc, wc, hc, sws, shs;
  logic               rej;
  wtb_cmd_t           cmd;

  assign sws = $signed({2'b00, sw});
  assign shs = $signed({2'b00, sh});

  // Clip the rectangle against the screen.
  always_comb begin
    x0 = 14'(signed'(in_ch.dest_x));
    y0 = 14'(signed'(in_ch.dest_y));
    w0 = 14'(signed'(in_ch.rect_width));
    h0 = 14'(signed'(in_ch.rect_height));
    rej = (x0 >= sws) || (y0 >= shs);
    xc = x0; yc = y0; wc = w0; hc = h0;
    if (xc < 0) begin
      wc = wc + xc;
      xc = '0;
    end
    if (yc < 0) begin
      hc = hc + yc;
      yc = '0;
    end
    if (xc + wc > sws) wc = sws - xc;
    if (yc + hc > shs) hc = shs - yc;
    if (wc <= 0 || hc <= 0) rej = 1'b1;
    cmd.advance    = in_ch.mode;
    cmd.reject     = rej;
    cmd.clip_left  = xc[10:0];
    cmd.clip_width = wc[11:0];
    cmd.dest_row   = yc[10:0];
    cmd.rows       = hc[11:0];
    cmd.offset_x   = in_ch.tex_offset_x;
    cmd.offset_y   = in_ch.tex_offset_y;
    cmd.phase      = in_ch.wave_phase;
    cmd.step       = in_ch.wave_step;
  end

  // Two-entry queue toward the back part.
  wtb_cmd_t   fifo [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ch.ready = (cnt != 2'd2);
  assign q_valid     = (cnt != 2'd0);
  assign q_cmd       = fifo[rp];

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) fifo[wp] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_ch.valid && in_ch.ready) - 2'(q_valid && q_ready);
    end
  end

endmodule

/* design/wtb_back.sv */
`include "wave_texture_blit_address_gen_macros.svh"
module wtb_back
  import wtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  wtb_cmd_t    q_cmd,
  input  logic [11:0] sw,
  input  logic [10:0] tw,
  input  logic [10:0] th,
  input  logic [15:0] amp,
  wtb_out_if.source   out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIST = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_PIX  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  logic        busy;
  logic [10:0] clip_left, dest_row;
  logic [11:0] clip_width, rows_left, column_count;
  logic [9:0]  source_row, source_column;
  logic [7:0]  phase_now, phase_step;
  logic [15:0] offset_x_held;

  // Shared restoring modulo unit: one quotient bit per cycle.
  logic [16:0] rem;
  logic [15:0] dvd;
  logic [4:0]  bitn;
  logic        mod_row;
  logic        mod_cmd;
  logic [31:0] prod;
  logic [16:0] rem_sh;

  logic        row_end_c, last_c;
  logic [9:0]  col_c, srow_c;
  wtb_res_t    res;
  logic        out_valid;

  assign rem_sh = {rem[15:0], dvd[15]};

  // Column and row are already below the texture size when a pixel is formed.
  always_comb begin
    col_c     = source_column;
    srow_c    = source_row;
    row_end_c = (13'(column_count) + 13'd1 >= 13'(clip_width));
    last_c    = row_end_c && (rows_left <= 12'd1);
  end

  assign q_ready = !out_valid && (state == S_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.status      = res.status;
  assign out_ch.src_address = res.src_address;
  assign out_ch.dst_address = res.dst_address;
  assign out_ch.row_end     = res.row_end;
  assign out_ch.last        = res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; busy <= 1'b0; out_valid <= 1'b0;
      clip_left <= '0; clip_width <= '0; dest_row <= '0; rows_left <= '0;
      column_count <= '0; source_row <= '0; source_column <= '0;
      phase_now <= '0; phase_step <= '0; offset_x_held <= '0;
      mod_row <= 1'b0; mod_cmd <= 1'b0; bitn <= '0; rem <= '0; dvd <= '0;
      prod <= '0;
      res <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            if (!q_cmd.advance) begin
              busy <= 1'b0;
              if (q_cmd.reject) begin
                res       <= '{ST_CLIPPED, 20'd0, 22'd0, 1'b0, 1'b0};
                out_valid <= 1'b1;
              end else begin
                res           <= '{ST_ACCEPTED, 20'd0, 22'd0, 1'b0, 1'b0};
                clip_left     <= q_cmd.clip_left;
                clip_width    <= q_cmd.clip_width;
                dest_row      <= q_cmd.dest_row;
                rows_left     <= q_cmd.rows;
                column_count  <= '0;
                source_column <= '0;
                phase_now     <= q_cmd.phase;
                phase_step    <= q_cmd.step;
                offset_x_held <= q_cmd.offset_x;
                dvd <= q_cmd.offset_y; rem <= '0; bitn <= 5'd16;
                mod_row <= 1'b1; mod_cmd <= 1'b1;
                state <= S_MOD;
              end
            end else if (!busy) begin
              res       <= '{ST_IDLE, 20'd0, 22'd0, 1'b0, 1'b0};
              out_valid <= 1'b1;
            end else if (column_count == '0) begin
              prod  <= amp * {16'd0, sine_plus_one(phase_now)};
              state <= S_DIST;
            end else begin
              state <= S_PIX;
            end
          end
        end
        S_DIST: begin
          dvd <= 16'(({1'b0, offset_x_held} + 17'((prod + 32'd2097152) >> 22)) % 17'd65536);
          rem <= {16'd0, ({1'b0, offset_x_held} + 17'((prod + 32'd2097152) >> 22)) >= 17'd65536};
          bitn <= 5'd16; mod_row <= 1'b0; mod_cmd <= 1'b0;
          phase_now <= phase_now + phase_step;
          state <= S_MOD;
        end
        S_MOD: begin
          if (bitn == 5'd0) begin
            if (mod_cmd) begin
              source_row <= rem[9:0];
              out_valid  <= 1'b1;
              state      <= S_IDLE;
            end else if (mod_row) begin
              source_row <= rem[9:0];
              state      <= S_PIX;
            end else begin
              source_column <= rem[9:0];
              state <= S_PIX;
            end
          end else begin
            if (rem_sh >= 17'(mod_row ? th : tw)) rem <= rem_sh - 17'(mod_row ? th : tw);
            else rem <= rem_sh;
            dvd  <= {dvd[14:0], 1'b0};
            bitn <= bitn - 5'd1;
          end
        end
        S_PIX: begin
          // A texture size written mid-command leaves a held row or column
          // that must be reduced before it is used.
          if (11'(source_row) >= th) begin
            dvd <= {6'd0, source_row}; rem <= '0; bitn <= 5'd16;
            mod_row <= 1'b1; mod_cmd <= 1'b0;
            state <= S_MOD;
          end else if (11'(source_column) >= tw) begin
            dvd <= {6'd0, source_column}; rem <= '0; bitn <= 5'd16;
            mod_row <= 1'b0; mod_cmd <= 1'b0;
            state <= S_MOD;
          end else begin
            prod  <= 32'(srow_c) * 32'(tw);
            state <= S_OUT;
          end
        end
        default: begin
          res <= '{ST_PIXEL, 20'(prod + 32'(col_c)),
                   22'(32'(dest_row) * 32'(sw) + 32'(clip_left) + 32'(column_count)),
                   row_end_c, last_c};
          out_valid <= 1'b1;
          if (row_end_c) begin
            column_count <= '0;
            dest_row     <= dest_row + 11'd1;
            rows_left    <= rows_left - 12'd1;
            source_row   <= (11'(srow_c) + 11'd1 >= th) ? 10'd0 : srow_c + 10'd1;
            if (last_c) busy <= 1'b0;
          end else begin
            column_count  <= column_count + 12'd1;
            source_column <= (11'(col_c) + 11'd1 >= tw) ? 10'd0 : col_c + 10'd1;
          end
          state <= S_IDLE;
        end
      endcase
      if (state == S_MOD && bitn == 5'd0 && mod_cmd) busy <= 1'b1;
    end
  end

  `WTB_ASSERT_IMP(a_no_take_while_full, out_valid, !q_ready, "took command with result pending")
  `WTB_ASSERT_NEXT(a_out_hold, out_valid && !out_ch.ready, out_valid, "result dropped")
  `WTB_ASSERT_IMP(a_pixel_busy, state == S_OUT, busy, "pixel while not busy")

endmodule

/* design/wave_texture_blit_address_gen.sv */
// Wave-distorted tiled texture blit address generator. A rejected start or an
// advance while idle is answered directly from the idle state; an accepted
// start answers once the 16-step bit-serial modulo of tex_offset_y by texture
// height is done. A pixel inside a row passes the pixel and output states; the
// first pixel of a row first passes the distortion state, where the distortion
// product is formed, and the 16-step modulo by texture width. A row or column
// held across a texture size change takes a further 16-step reduction through
// the modulo unit for each held value. The back part takes the next command
// only once its result has been accepted, so it never works on two commands at
// once. A two-entry command queue sits between the clipping front and the
// address back.
module wave_texture_blit_address_gen
  import wtb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  wtb_in_if.sink    in_ch,
  wtb_cfg_if.sink   cfg,
  wtb_out_if.source out_ch
);

  logic [11:0] screen_width, screen_height;
  logic [10:0] texture_width, texture_height;
  logic [15:0] wave_amplitude;
  logic [11:0] sw, sh;
  logic [10:0] tw, th;
  logic        q_valid, q_ready;
  wtb_cmd_t    q_cmd;

  assign cfg.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 12'd320; screen_height <= 12'd240;
      texture_width <= 11'd256; texture_height <= 11'd256;
      wave_amplitude <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SCREEN_WIDTH:   screen_width   <= cfg.data[11:0];
        REG_SCREEN_HEIGHT:  screen_height  <= cfg.data[11:0];
        REG_TEXTURE_WIDTH:  texture_width  <= cfg.data[10:0];
        REG_TEXTURE_HEIGHT: texture_height <= cfg.data[10:0];
        REG_WAVE_AMPLITUDE: wave_amplitude <= cfg.data;
        default: ;
      endcase
    end
  end

  // Dimensions clamped to their legal ranges.
  always_comb begin
    sw = (screen_width == '0) ? 12'd1 :
         (screen_width > 12'(MAX_SCREEN_DIM)) ? 12'(MAX_SCREEN_DIM) : screen_width;
    sh = (screen_height == '0) ? 12'd1 :
         (screen_height > 12'(MAX_SCREEN_DIM)) ? 12'(MAX_SCREEN_DIM) : screen_height;
    tw = (texture_width == '0) ? 11'd1 :
         (texture_width > 11'(MAX_TEXTURE_DIM)) ? 11'(MAX_TEXTURE_DIM) : texture_width;
    th = (texture_height == '0) ? 11'd1 :
         (texture_height > 11'(MAX_TEXTURE_DIM)) ? 11'(MAX_TEXTURE_DIM) : texture_height;
  end

  wtb_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .sw(sw), .sh(sh),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  wtb_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .sw(sw), .tw(tw), .th(th), .amp(wave_amplitude), .out_ch(out_ch)
  );

endmodule

/* test/tb_wave_texture_blit_address_gen_if.sv */
// Interfaces are provided by the design; this file holds the testbench
// transaction types shared by the test tasks.
package tb_wtb_types_pkg;
  typedef struct packed {
    logic        mode;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
    logic [15:0] tex_offset_x;
    logic [15:0] tex_offset_y;
    logic [7:0]  wave_phase;
    logic [7:0]  wave_step;
  } blit_item_t;
endpackage

/* test/tb_wave_texture_blit_address_gen.sv */
module tb_wave_texture_blit_address_gen;
  import wtb_pkg::*;
  import tb_wtb_types_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  wtb_in_if in_ch();
  wtb_cfg_if cfg();
  wtb_out_if out_ch();

  wave_texture_blit_address_gen dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch)
  );

  // Predictor state and register copies.
  int unsigned scr_w, scr_h, tex_w, tex_h, amp;
  int unsigned busy_p, left_p, width_p, drow_p, rows_p, col_cnt, srow_p, scol_p;
  int unsigned phase_p, step_p, offx_p;
  wtb_res_t expected_pixels[$];
  int errors;
  int cycles;
  bit quiet;
  bit hold_long;

  localparam int CYCLE_LIMIT = 3000000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with a generous timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned wave_shift(int unsigned ph);
    int unsigned q[65] = '{0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590,
      3981, 4370, 4756, 5139, 5520, 5897, 6270, 6639, 7005, 7366,
      7723, 8076, 8423, 8765, 9102, 9434, 9760, 10080, 10394, 10702,
      11003, 11297, 11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
      13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978, 15137, 15286,
      15426, 15557, 15679, 15791, 15893, 15986, 16069, 16143, 16207, 16261,
      16305, 16340, 16364, 16379, 16384};
    int unsigned s;
    longint unsigned prod;
    ph = ph & 255;
    if (ph < 64) s = 16384 + q[ph];
    else if (ph < 128) s = 16384 + q[128 - ph];
    else if (ph < 192) s = 16384 - q[ph - 128];
    else s = 16384 - q[256 - ph];
    prod = longint'(amp) * s + (1 << 21);
    return int'(prod >> 22);
  endfunction

  // Computes the result that one accepted item causes.
  function automatic wtb_res_t blit_predict(blit_item_t it);
    wtb_res_t r;
    int unsigned sw, sh, tw, th, col, srow, re, lst;
    int x, y, w, h;
    longint unsigned a;
    sw = clamp_dim(scr_w, MAX_SCREEN_DIM);
    sh = clamp_dim(scr_h, MAX_SCREEN_DIM);
    tw = clamp_dim(tex_w, MAX_TEXTURE_DIM);
    th = clamp_dim(tex_h, MAX_TEXTURE_DIM);
    r = '0;
    if (!it.mode) begin
      x = int'($signed(it.dest_x));
      y = int'($signed(it.dest_y));
      w = int'($signed(it.rect_width));
      h = int'($signed(it.rect_height));
      busy_p = 0;
      if (x >= int'(sw) || y >= int'(sh)) begin
        r.status = ST_CLIPPED;
        return r;
      end
      if (x < 0) begin w += x; x = 0; end
      if (y < 0) begin h += y; y = 0; end
      if (x + w > int'(sw)) w = sw - x;
      if (y + h > int'(sh)) h = sh - y;
      if (w <= 0 || h <= 0) begin
        r.status = ST_CLIPPED;
        return r;
      end
      busy_p = 1; left_p = x; width_p = w; drow_p = y; rows_p = h;
      col_cnt = 0; srow_p = 32'(it.tex_offset_y) % th; scol_p = 0;
      phase_p = 32'(it.wave_phase); step_p = 32'(it.wave_step);
      offx_p = 32'(it.tex_offset_x);
      r.status = ST_ACCEPTED;
      return r;
    end
    if (!busy_p) begin
      r.status = ST_IDLE;
      return r;
    end
    if (col_cnt == 0) begin
      scol_p = (offx_p + wave_shift(phase_p)) % tw;
      phase_p = (phase_p + step_p) & 255;
    end
    col = scol_p % tw;
    srow = srow_p % th;
    re = (col_cnt + 1 >= width_p);
    lst = re && rows_p <= 1;
    r.status = ST_PIXEL;
    a = longint'(srow) * tw + col;
    r.src_address = a[19:0];
    a = longint'(drow_p) * sw + left_p + col_cnt;
    r.dst_address = a[21:0];
    r.row_end = re[0];
    r.last = lst[0];
    if (re) begin
      col_cnt = 0;
      drow_p = (drow_p + 1) & 12'h7FF;
      rows_p = (rows_p - 1) & 12'hFFF;
      srow_p = (srow + 1 >= th) ? 0 : srow + 1;
      if (lst) busy_p = 0;
    end else begin
      col_cnt = (col_cnt + 1) & 12'hFFF;
      scol_p = (col + 1 >= tw) ? 0 : col + 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic random_gap();
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  // Sends one transaction and records its expected result.
  task automatic send_item(blit_item_t it);
    random_gap();
    in_ch.valid = 1'b1;
    {in_ch.mode, in_ch.dest_x, in_ch.dest_y, in_ch.rect_width, in_ch.rect_height,
     in_ch.tex_offset_x, in_ch.tex_offset_y, in_ch.wave_phase, in_ch.wave_step} = it;
    // Ready only moves at the rising edge, so it is stable here.
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    expected_pixels.push_back(blit_predict(it));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_SCREEN_WIDTH: scr_w = val & 12'hFFF;
      REG_SCREEN_HEIGHT: scr_h = val & 12'hFFF;
      REG_TEXTURE_WIDTH: tex_w = val & 11'h7FF;
      REG_TEXTURE_HEIGHT: tex_h = val & 11'h7FF;
      REG_WAVE_AMPLITUDE: amp = val;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic blit_item_t make_start(int x, int y, int w, int h);
    blit_item_t it;
    it.mode = 1'b0;
    it.dest_x = 12'(x); it.dest_y = 12'(y);
    it.rect_width = 13'(w); it.rect_height = 13'(h);
    it.tex_offset_x = 16'($urandom); it.tex_offset_y = 16'($urandom);
    it.wave_phase = 8'($urandom); it.wave_step = 8'($urandom);
    return it;
  endfunction

  function automatic blit_item_t make_advance();
    blit_item_t it;
    it = '0;
    it.dest_x = 12'($urandom); it.rect_width = 13'($urandom);
    it.tex_offset_x = 16'($urandom); it.wave_phase = 8'($urandom);
    it.mode = 1'b1;
    return it;
  endfunction

  // Receiver: random stalls, one long hold-off, and checking.
  always @(negedge clk) begin
    if (rst || hold_long) out_ch.ready <= 1'b0;
    else if (quiet) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 4) != 0);
  end

  always @(posedge clk) begin
    wtb_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", out_ch.status, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (out_ch.status !== want.status) report_mismatch("status", out_ch.status, want.status);
        if (out_ch.src_address !== want.src_address)
          report_mismatch("src_address", out_ch.src_address, want.src_address);
        if (out_ch.dst_address !== want.dst_address)
          report_mismatch("dst_address", out_ch.dst_address, want.dst_address);
        if (out_ch.row_end !== want.row_end) report_mismatch("row_end", out_ch.row_end, want.row_end);
        if (out_ch.last !== want.last) report_mismatch("last", out_ch.last, want.last);
      end
    end
  end

  task automatic test_directed();
    send_item(make_advance());
    send_item(make_start(2047, 0, 4, 4));
    send_item(make_start(0, 2047, 4, 4));
    send_item(make_start(-2048, -2048, 4095, 4095));
    send_item(make_start(-5, -3, 8, 5));
    repeat (8) send_item(make_advance());
    send_item(make_start(0, 0, -4096, 3));
    send_item(make_start(318, 238, 4, 4));
    repeat (5) send_item(make_advance());
    send_item(make_start(10, 10, 3, 2));
    send_item(make_advance());
    send_item(make_start(0, 0, 1, 1));
    send_item(make_advance());
    send_item(make_advance());
  endtask

  task automatic test_wave_extremes();
    write_reg(REG_WAVE_AMPLITUDE, 16'hFFFF);
    write_reg(REG_TEXTURE_WIDTH, 16'd3);
    write_reg(REG_TEXTURE_HEIGHT, 16'd1);
    send_item(make_start(0, 0, 4, 3));
    repeat (12) send_item(make_advance());
    write_reg(REG_TEXTURE_WIDTH, 16'h07FF);
    write_reg(REG_TEXTURE_HEIGHT, 16'd0);
    write_reg(REG_SCREEN_WIDTH, 16'h0FFF);
    write_reg(REG_SCREEN_HEIGHT, 16'd0);
    send_item(make_start(2040, 0, 20, 2));
    repeat (10) send_item(make_advance());
  endtask

  // Mostly well-formed commands followed by their pixels, with some noise.
  task automatic test_random_blits(int items);
    int n, w, h, k;
    n = 0;
    while (n < items) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 4);
      send_item(make_start($urandom_range(0, 30) - 8, $urandom_range(0, 30) - 6, w, h));
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h) : w * h + 1;
      repeat (k) send_item(make_advance());
      n += k + 1;
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_start($urandom, $urandom, $urandom, $urandom));
        n++;
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_long = 1'b1;
        repeat (300) @(negedge clk);
        hold_long = 1'b0;
      end
      begin
        send_item(make_start(0, 0, 40, 2));
        repeat (40) send_item(make_advance());
      end
    join
  endtask

  initial begin
    blit_item_t idle_item;
    idle_item = '0;
    rst = 1'b1;
    errors = 0; cycles = 0; quiet = 0; hold_long = 0;
    in_ch.valid = 1'b0;
    {in_ch.mode, in_ch.dest_x, in_ch.dest_y, in_ch.rect_width, in_ch.rect_height,
     in_ch.tex_offset_x, in_ch.tex_offset_y, in_ch.wave_phase, in_ch.wave_step} = idle_item;
    cfg.valid = 1'b0; cfg.index = REG_SCREEN_WIDTH; cfg.data = '0;
    out_ch.ready = 1'b0;
    scr_w = 320; scr_h = 240; tex_w = 256; tex_h = 256; amp = 0;
    busy_p = 0; left_p = 0; width_p = 0; drow_p = 0; rows_p = 0; col_cnt = 0;
    srow_p = 0; scol_p = 0; phase_p = 0; step_p = 0; offx_p = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_wave_extremes();
    write_reg(REG_SCREEN_WIDTH, 16'd64);
    write_reg(REG_SCREEN_HEIGHT, 16'd48);
    write_reg(REG_TEXTURE_WIDTH, 16'd17);
    write_reg(REG_TEXTURE_HEIGHT, 16'd1024);
    write_reg(REG_WAVE_AMPLITUDE, 16'h0A80);
    test_backpressure();
    test_random_blits(900);
    write_reg(REG_TEXTURE_WIDTH, 16'd1024);
    write_reg(REG_TEXTURE_HEIGHT, 16'd5);
    write_reg(REG_WAVE_AMPLITUDE, 16'h0000);
    write_reg(REG_SCREEN_WIDTH, 16'd1);
    test_random_blits(300);
    write_reg(REG_SCREEN_WIDTH, 16'd2048);
    write_reg(REG_SCREEN_HEIGHT, 16'd2048);
    write_reg(REG_WAVE_AMPLITUDE, 16'h3F00);
    quiet = 1'b1;
    test_random_blits(600);

    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/wtb_pkg.sv
design/wtb_if.sv
design/wtb_out_if.sv
design/wtb_cfg_if.sv
design/wtb_front.sv
design/wtb_back.sv
design/wave_texture_blit_address_gen.sv
test/tb_wave_texture_blit_address_gen_if.sv
test/tb_wave_texture_blit_address_gen.sv
